[sv/tpts_pkg.sv]
// ----------------------------------------------------------------------------
// tpts_pkg
// Shared types and constants for the tick priority task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tpts_pkg;

    localparam int NUM_TASKS = 8;
    localparam int TASK_W    = $clog2(NUM_TASKS);
    localparam int CNT_W     = 8;
    localparam int PRIO_W    = 7;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 8;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DEC,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_CHECK,
        ST_REFILL,
        ST_RESP
    } tpts_state_t;

    typedef struct packed {
        logic latch_in;
        logic do_load;
        logic do_dec;
        logic scan_init;
        logic scan_step;
        logic refill_init;
        logic refill_step;
        logic take_best;
        logic set_none;
        logic out_load;
    } tpts_cmd_t;

    typedef struct packed {
        logic func;
        logic running_nz;
        logic dec_zero;
        logic ptr_first;
        logic ptr_last;
        logic best_nz;
        logic refilled;
        logic out_free;
    } tpts_stat_t;

endpackage

`default_nettype wire

[sv/tpts_ctrl.sv]
// ----------------------------------------------------------------------------
// tpts_ctrl
// Sequencer: steps the datapath through load, decrement, scan and refill.
// ----------------------------------------------------------------------------
`default_nettype none

module tpts_ctrl
    import tpts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire tpts_stat_t stat,
    output tpts_cmd_t       cmd
);

    tpts_state_t state_reg;
    tpts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // The latched word is decoded here.
                if (stat.func == FUNC_LOAD)
                begin
                    cmd.do_load = 1'b1;
                    state_next  = ST_RESP;
                end
                else if (stat.running_nz)
                begin
                    state_next = ST_DEC;
                end
                else
                begin
                    state_next = ST_SCAN_INIT;
                end
            end
            ST_DEC:
            begin
                cmd.do_dec = 1'b1;
                state_next = stat.dec_zero ? ST_SCAN_INIT : ST_RESP;
            end
            ST_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.ptr_first)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.best_nz)
                begin
                    cmd.take_best = 1'b1;
                    state_next    = ST_RESP;
                end
                else if (!stat.refilled)
                begin
                    cmd.refill_init = 1'b1;
                    state_next      = ST_REFILL;
                end
                else
                begin
                    cmd.set_none = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_REFILL:
            begin
                cmd.refill_step = 1'b1;
                if (stat.ptr_last)
                begin
                    state_next = ST_SCAN_INIT;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/tpts_dp.sv]
// ----------------------------------------------------------------------------
// tpts_dp
// Datapath: task table, scan pointer, best-candidate registers and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module tpts_dp
    import tpts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata,
    input  wire tpts_cmd_t        cmd,
    output tpts_stat_t            stat
);

    localparam logic [TASK_W-1:0] LAST_IDX  = TASK_W'(NUM_TASKS - 1);
    localparam logic [TASK_W-1:0] FIRST_IDX = TASK_W'(1);

    logic [CNT_W-1:0]  cnt_reg [NUM_TASKS];
    logic [PRIO_W-1:0] prio_reg [NUM_TASKS];

    logic              func_reg;
    logic [TASK_W-1:0] idx_reg;
    logic [CNT_W-1:0]  cval_reg;
    logic [PRIO_W-1:0] pval_reg;

    logic [TASK_W-1:0] running_reg;
    logic [TASK_W-1:0] prev_reg;
    logic [TASK_W-1:0] ptr_reg;
    logic [TASK_W-1:0] best_reg;
    logic [CNT_W-1:0]  best_val_reg;
    logic              refilled_reg;
    logic              none_reg;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [TASK_W-1:0] addr;
    logic [CNT_W-1:0]  rd_cnt;
    logic [CNT_W-1:0]  dec_val;
    logic [CNT_W:0]    refill_sum;
    logic [CNT_W-1:0]  refill_val;

    // One read port on the counter table, shared by decrement, scan and refill.
    assign addr    = cmd.do_dec ? running_reg : ptr_reg;
    assign rd_cnt  = cnt_reg[addr];
    assign dec_val = (rd_cnt == '0) ? '0 : rd_cnt - CNT_W'(1);

    assign refill_sum = {2'b00, rd_cnt[CNT_W-1:1]} + {{(CNT_W + 1 - PRIO_W){1'b0}}, prio_reg[addr]};
    assign refill_val = refill_sum[CNT_W] ? {CNT_W{1'b1}} : refill_sum[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                cnt_reg[i]  <= '0;
                prio_reg[i] <= '0;
            end
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_load && idx_reg != '0)
            begin
                cnt_reg[idx_reg]  <= cval_reg;
                prio_reg[idx_reg] <= pval_reg;
            end
            if (cmd.do_dec)
            begin
                cnt_reg[addr] <= dec_val;
            end
            if (cmd.refill_step)
            begin
                cnt_reg[addr] <= refill_val;
            end
            if (cmd.take_best)
            begin
                running_reg <= best_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg     <= s_tuser;
            idx_reg      <= s_tdata[TASK_W-1:0];
            cval_reg     <= s_tdata[TASK_W+CNT_W-1:TASK_W];
            pval_reg     <= s_tdata[TASK_W+CNT_W+PRIO_W-1:TASK_W+CNT_W];
            prev_reg     <= running_reg;
            refilled_reg <= 1'b0;
            none_reg     <= 1'b0;
        end
        if (cmd.scan_init)
        begin
            ptr_reg      <= LAST_IDX;
            best_reg     <= '0;
            best_val_reg <= '0;
        end
        // Scan runs from the highest index down; strict compare keeps ties high.
        if (cmd.scan_step)
        begin
            if (rd_cnt > best_val_reg)
            begin
                best_val_reg <= rd_cnt;
                best_reg     <= ptr_reg;
            end
            ptr_reg <= ptr_reg - TASK_W'(1);
        end
        if (cmd.refill_init)
        begin
            ptr_reg      <= FIRST_IDX;
            refilled_reg <= 1'b1;
        end
        if (cmd.refill_step)
        begin
            ptr_reg <= ptr_reg + TASK_W'(1);
        end
        if (cmd.set_none)
        begin
            none_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {2'b00, none_reg, refilled_reg,
                             running_reg != prev_reg, running_reg};
        end
    end

    assign stat.func       = func_reg;
    assign stat.running_nz = running_reg != '0;
    assign stat.dec_zero   = dec_val == '0;
    assign stat.ptr_first  = ptr_reg == FIRST_IDX;
    assign stat.ptr_last   = ptr_reg == LAST_IDX;
    assign stat.best_nz    = best_reg != '0;
    assign stat.refilled   = refilled_reg;
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[sv/tick_priority_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// tick_priority_task_scheduler_unit
// Time-slice scheduler: load task entries; on each timer tick run the current
// task down and, when it runs out, pick the task with the largest remaining slice.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata / tuser                                   Words
//  s_*      in         tdata: task_index[2:0], counter_value[10:3],    1 per item
//                      priority_value[17:11]; tuser: func
//  m_*      out        tdata: current_task[2:0], switched[3],          1 per item
//                      refilled[4], no_runnable[5]
//
// A load passes through the load and response states; a tick that keeps the
// running task passes through load, decrement and response. A tick that
// schedules walks the seven task entries once per scan and once for a refill,
// one entry a cycle through the single counter read port. One item is in work
// at a time; the input is accepted again as soon as the result sits in the
// output register, even while that word waits for m_tready. Reset clears the
// table.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_priority_task_scheduler_unit
    import tpts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // task_index, counter_value, priority_value
    input  wire logic             s_tuser,   // func
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata    // current_task, switched, refilled, no_runnable
);

    tpts_cmd_t  cmd;
    tpts_stat_t stat;

    tpts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpts_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

[tb/sv/tb_tick_priority_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// tb_tick_priority_task_scheduler_unit
// Self-checking bench for the tick priority task scheduler. It loads task
// slots and sends timer ticks on the input stream. A local model of the task
// table predicts every result word, and the words on the output stream are
// compared against that prediction field by field. Both streams insert random
// idle gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tick_priority_task_scheduler_unit
    import tpts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = 40;

    // Listed from the top bit down, so that the word casts straight onto it.
    typedef struct packed {
        logic              no_runnable;
        logic              refilled;
        logic              switched;
        logic [TASK_W-1:0] cur_task;
    } sched_result_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tuser  = FUNC_LOAD;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // Local copy of the task table.
    logic [CNT_W-1:0]  slice_cnt [NUM_TASKS];
    logic [PRIO_W-1:0] prio_tab  [NUM_TASKS];
    logic [TASK_W-1:0] run_task;

    sched_result_t pending_sched[$];

    int  err_count    = 0;
    int  cycle_count  = 0;
    int  load_count   = 0;
    int  tick_count   = 0;
    int  switch_count = 0;
    int  refill_count = 0;
    int  starve_count = 0;
    int  word_count   = 0;
    bit  tx_gaps_on   = 1'b1;
    bit  rx_gaps_on   = 1'b1;
    int  rx_stall     = 0;

    tick_priority_task_scheduler_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending", cycle_count,
                     pending_sched.size());
            $display("tb_tick_priority_task_scheduler_unit: done, errors");
            $finish;
        end
    end

    // Mostly no gap, otherwise a short one, now and then a long one.
    function automatic int gap_len(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Largest nonzero slice wins; the scan runs downward so ties keep the
    // highest index.
    function automatic logic [TASK_W-1:0] pick_largest();
        logic [TASK_W-1:0] best;
        logic [CNT_W-1:0]  best_val;
        best     = '0;
        best_val = '0;
        for (int i = NUM_TASKS - 1; i > 0; i--)
        begin
            if (slice_cnt[i] > best_val)
            begin
                best_val = slice_cnt[i];
                best     = TASK_W'(i);
            end
        end
        return best;
    endfunction

    function automatic sched_result_t predict_schedule(logic func, logic [TASK_W-1:0] idx,
                                                       logic [CNT_W-1:0] cval,
                                                       logic [PRIO_W-1:0] pval);
        sched_result_t     res;
        logic [TASK_W-1:0] prev;
        logic [TASK_W-1:0] next;
        logic              do_sched;
        int                sum;
        prev = run_task;
        res  = '0;
        if (func == FUNC_LOAD)
        begin
            if (idx != 0)
            begin
                slice_cnt[idx] = cval;
                prio_tab[idx]  = pval;
            end
        end
        else
        begin
            do_sched = 1'b1;
            if (run_task != 0)
            begin
                if (slice_cnt[run_task] != 0)
                    slice_cnt[run_task] = slice_cnt[run_task] - CNT_W'(1);
                do_sched = (slice_cnt[run_task] == 0);
            end
            if (do_sched)
            begin
                next = pick_largest();
                if (next == 0)
                begin
                    for (int i = 1; i < NUM_TASKS; i++)
                    begin
                        sum = int'(slice_cnt[i] >> 1) + int'(prio_tab[i]);
                        slice_cnt[i] = (sum > 255) ? 8'd255 : CNT_W'(sum);
                    end
                    res.refilled = 1'b1;
                    next = pick_largest();
                    if (next == 0)
                        res.no_runnable = 1'b1;
                end
                if (next != 0)
                    run_task = next;
            end
        end
        res.cur_task = run_task;
        res.switched = (run_task != prev);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d, word %0d: %s", cycle_count, word_count, msg);
        err_count++;
    endtask

    // Sends one word and records its prediction once the word is taken. The
    // valid stays high when the next word follows without a gap.
    task automatic send_word(logic func, logic [TASK_W-1:0] idx, logic [CNT_W-1:0] cval,
                             logic [PRIO_W-1:0] pval);
        int            gap;
        sched_result_t res;
        gap = gap_len(tx_gaps_on);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(IN_W - TASK_W - CNT_W - PRIO_W){1'b0}}, pval, cval, idx};
        do
            @(posedge clk);
        while (!s_tready);
        res = predict_schedule(func, idx, cval, pval);
        pending_sched.push_back(res);
        if (func == FUNC_LOAD)
            load_count++;
        else
            tick_count++;
        if (res.switched)
            switch_count++;
        if (res.refilled)
            refill_count++;
        if (res.no_runnable)
            starve_count++;
    endtask

    task automatic load_slot(int idx, int cval, int pval);
        send_word(FUNC_LOAD, TASK_W'(idx), CNT_W'(cval), PRIO_W'(pval));
    endtask

    task automatic tick();
        send_word(FUNC_TICK, TASK_W'($urandom_range(0, 7)), CNT_W'($urandom_range(0, 255)),
                  PRIO_W'($urandom_range(0, 127)));
    endtask

    // Output side: random back-pressure in bursts.
    always @(posedge clk)
    begin
        if (rx_stall > 0)
        begin
            rx_stall--;
            m_tready <= 1'b0;
        end
        else if (rx_gaps_on && $urandom_range(0, 99) < 25)
        begin
            rx_stall = gap_len(1'b1);
            m_tready <= (rx_stall == 0);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        sched_result_t exp_res;
        sched_result_t got_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            word_count++;
            got_res = sched_result_t'(m_tdata[5:0]);
            if (pending_sched.size() == 0)
                report_mismatch($sformatf("unexpected word %h", m_tdata));
            else
            begin
                exp_res = pending_sched.pop_front();
                if (got_res.cur_task !== exp_res.cur_task)
                    report_mismatch($sformatf("current_task %0d, expected %0d",
                                              got_res.cur_task, exp_res.cur_task));
                if (got_res.switched !== exp_res.switched)
                    report_mismatch($sformatf("switched %b, expected %b",
                                              got_res.switched, exp_res.switched));
                if (got_res.refilled !== exp_res.refilled)
                    report_mismatch($sformatf("refilled %b, expected %b",
                                              got_res.refilled, exp_res.refilled));
                if (got_res.no_runnable !== exp_res.no_runnable)
                    report_mismatch($sformatf("no_runnable %b, expected %b",
                                              got_res.no_runnable, exp_res.no_runnable));
            end
        end
    end

    // A tick on the empty table finds nothing to run; loads to the idle slot
    // must not change that.
    task automatic test_empty_table();
        tick();
        load_slot(0, 255, 127);
        tick();
    endtask

    task automatic test_pick_and_slices();
        // Equal slices after a refill: the higher slot wins.
        load_slot(7, 0, 127);
        load_slot(3, 0, 127);
        tick();
        load_slot(1, 255, 0);
        tick();
        // Running slot reloaded with zero: decrement saturates and it reschedules.
        load_slot(7, 0, 127);
        tick();
        // Slice runs out normally.
        load_slot(1, 1, 0);
        tick();
    endtask

    task automatic test_reselect_and_starve();
        // Only the running slot has a priority, so the refill picks it again.
        load_slot(3, 1, 5);
        load_slot(7, 0, 0);
        load_slot(1, 0, 0);
        tick();
        // No priorities left: the running slot is kept and starvation is flagged.
        load_slot(3, 1, 0);
        tick();
        load_slot(5, 2, 64);
        tick();
    endtask

    // Mostly ticks with loads mixed in, many of small slices, so that slices run out
    // and refills happen; now and then the whole table is cleared of priority.
    task automatic test_random_traffic();
        int sent;
        int r;
        int cval;
        int pval;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 50 == 0)
            begin
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_gaps_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                for (int i = 1; i < NUM_TASKS; i++)
                    load_slot(i, $urandom_range(0, 2), 0);
                sent += NUM_TASKS - 1;
            end
            else if (r < 38)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    cval = $urandom_range(0, 4);
                else if (r < 90)
                    cval = $urandom_range(0, 255);
                else
                    cval = $urandom_range(250, 255);
                r = $urandom_range(0, 99);
                if (r < 15)
                    pval = 0;
                else if (r < 50)
                    pval = $urandom_range(0, 7);
                else
                    pval = $urandom_range(0, 127);
                load_slot($urandom_range(0, 7), cval, pval);
                sent++;
            end
            else
            begin
                tick();
                sent++;
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            slice_cnt[i] = '0;
            prio_tab[i]  = '0;
        end
        run_task = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_pick_and_slices();
        test_reselect_and_starve();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (pending_sched.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d ticks, %0d result words checked",
                 load_count, tick_count, word_count);
        $display("ticks gave %0d task switches, %0d refills, %0d with nothing runnable",
                 switch_count, refill_count, starve_count);
        if (err_count == 0)
            $display("tb_tick_priority_task_scheduler_unit: done, clean");
        else
            $display("tb_tick_priority_task_scheduler_unit: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
sv/tpts_pkg.sv
sv/tpts_ctrl.sv
sv/tpts_dp.sv
sv/tick_priority_task_scheduler_unit.sv
tb/sv/tb_tick_priority_task_scheduler_unit.sv
